// ===== design/magfc_pkg.sv =====
// ----------------------------------------------------------------------------
// magfc_pkg: shared definitions for the magnetometer frame converter
// Register indexes, field widths, the gain table and the reciprocal constants
// used for the divisions by 100, 125 and the temperature divisor.
// ----------------------------------------------------------------------------
package magfc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int TEMP_W  = 19;
    localparam int FIELD_W = 24;

    // Error flag position in the status byte.
    localparam int STATUS_ERR_POS = 4;

    // Resolution codes that remove an offset from the axis word.
    localparam logic [1:0] RES_OFFSET_HALF    = 2'd2;
    localparam logic [1:0] RES_OFFSET_QUARTER = 2'd3;
    localparam logic [15:0] AXIS_OFFSET_HALF    = 16'h8000;
    localparam logic [15:0] AXIS_OFFSET_QUARTER = 16'h4000;

    localparam logic [9:0] TEMP_SCALE = 10'd1000;

    // Divisor of the scaled temperature difference.
    localparam int TEMP_DIVISOR = 452;

    // Exact floor division by a constant d for n < 2^N:
    // floor(n / d) == (n * ceil(2^(N+L) / d)) >> (N+L), with L = ceil(log2 d).
    // Division by 100, numerator below 2^24.
    localparam logic [24:0] RECIP_100      = 25'd21474837;
    localparam int          RECIP_100_SHR  = 31;
    // Division by 125, numerator below 2^30.
    localparam logic [30:0] RECIP_125      = 31'd1099511628;
    localparam int          RECIP_125_SHR  = 37;
    // Division by the temperature divisor 452, numerator below 2^26.
    localparam logic [26:0] RECIP_TEMP     = 27'd76017121;
    localparam int          RECIP_TEMP_SHR = 35;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_SELECT       = 3'd0,
        REG_RESOLUTION_SELECT = 3'd1,
        REG_REFERENCE_TEMP    = 3'd2,
        REG_XY_SENSITIVITY    = 3'd3,
        REG_Z_SENSITIVITY     = 3'd4,
        REG_TEMP_OFFSET       = 3'd5
    } cfg_index_t;

    // Gain in hundredths for each gain code.
    function automatic logic [8:0] gain_lookup(input logic [2:0] code);
        logic [8:0] g;
        case (code)
            3'd0:    g = 9'd500;
            3'd1:    g = 9'd400;
            3'd2:    g = 9'd300;
            3'd3:    g = 9'd250;
            3'd4:    g = 9'd200;
            3'd5:    g = 9'd167;
            3'd6:    g = 9'd133;
            default: g = 9'd100;
        endcase
        return g;
    endfunction

endpackage

// ===== design/magnetometer_frame_converter_core.sv =====
// ----------------------------------------------------------------------------
// magnetometer_frame_converter_core
// Converts one raw measurement frame into a temperature and three field
// values through a four-stage pipeline.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  --------  --------------------  ------------------------------------------
//  frame in  start / busy          status_byte, raw_temp_word, raw_*_word
//  result    done (one cycle)      temp_value, field_x/y/z, read_error
//  config    wr_en                 wr_index, wr_data
//
// One frame is accepted in every cycle; busy is always low. Each result
// passes through the four registered stages, one stage per multiplier.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
// With these ranges neither the temperature nor the fields can exceed
// their output widths, so no saturation logic is required.
//
module magnetometer_frame_converter_core
    import magfc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          start,
    output logic                          busy,
    input  logic [7:0]                    status_byte,
    input  logic [15:0]                   raw_temp_word,
    input  logic [15:0]                   raw_x_word,
    input  logic [15:0]                   raw_y_word,
    input  logic [15:0]                   raw_z_word,

    output logic                          done,
    output logic signed [TEMP_W-1:0]      temp_value,
    output logic signed [FIELD_W-1:0]     field_x,
    output logic signed [FIELD_W-1:0]     field_y,
    output logic signed [FIELD_W-1:0]     field_z,
    output logic                          read_error,

    input  logic                          wr_en,
    input  logic [CFG_INDEX_W-1:0]        wr_index,
    input  logic [CFG_DATA_W-1:0]         wr_data
);

    // Configuration registers.
    logic [2:0]  gain_select_reg;
    logic [1:0]  resolution_select_reg;
    logic [15:0] reference_temp_reg;
    logic [11:0] xy_sensitivity_reg;
    logic [11:0] z_sensitivity_reg;
    logic [15:0] temp_offset_reg;

    // Pipeline valid bits and error flags.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic err1_reg, err2_reg, err3_reg;

    // Axis lanes: 0 = x, 1 = y, 2 = z.
    logic        neg1_reg [3];
    logic        neg2_reg [3];
    logic        neg3_reg [3];
    logic [23:0] prod1_reg [3];
    logic [17:0] quot2_reg [3];
    logic [29:0] scaled3_reg [3];

    logic        tneg1_reg, tneg2_reg;
    logic [25:0] tprod1_reg;
    logic [17:0] tquot2_reg;
    logic [TEMP_W-1:0] temp3_reg;

    // Stage-input values.
    logic        neg1_next [3];
    logic [23:0] prod1_next [3];
    logic [17:0] quot2_next [3];
    logic [29:0] scaled3_next [3];
    logic [FIELD_W-1:0] field4_next [3];
    logic        tneg1_next;
    logic [25:0] tprod1_next;
    logic [17:0] tquot2_next;
    logic [TEMP_W-1:0] temp3_next;

    logic [TEMP_W-1:0]  temp_value_reg;
    logic [FIELD_W-1:0] field_x_reg, field_y_reg, field_z_reg;
    logic               read_error_reg;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_select_reg       <= 3'd7;
            resolution_select_reg <= 2'd0;
            reference_temp_reg    <= 16'd0;
            xy_sensitivity_reg    <= 12'd150;
            z_sensitivity_reg     <= 12'd242;
            temp_offset_reg       <= 16'd250;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_GAIN_SELECT:       gain_select_reg       <= wr_data[2:0];
                REG_RESOLUTION_SELECT: resolution_select_reg <= wr_data[1:0];
                REG_REFERENCE_TEMP:    reference_temp_reg    <= wr_data;
                REG_XY_SENSITIVITY:    xy_sensitivity_reg    <= wr_data[11:0];
                REG_Z_SENSITIVITY:     z_sensitivity_reg     <= wr_data[11:0];
                REG_TEMP_OFFSET:       temp_offset_reg       <= wr_data;
                default:               ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offset removal, sign/magnitude split and gain; temperature x1000
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [15:0] w;
        logic [15:0] mag;
        logic [15:0] raw_w [3];
        logic [16:0] tdiff;
        logic [15:0] tmag;
        raw_w[0] = raw_x_word;
        raw_w[1] = raw_y_word;
        raw_w[2] = raw_z_word;
        for (int i = 0; i < 3; i++)
        begin
            case (resolution_select_reg)
                RES_OFFSET_HALF:    w = raw_w[i] - AXIS_OFFSET_HALF;
                RES_OFFSET_QUARTER: w = raw_w[i] - AXIS_OFFSET_QUARTER;
                default:            w = raw_w[i];
            endcase
            mag = w[15] ? (~w + 16'd1) : w;
            neg1_next[i]  = w[15];
            prod1_next[i] = 24'(mag) * 24'(gain_lookup(gain_select_reg));
        end
        tdiff       = {1'b0, raw_temp_word} - {1'b0, reference_temp_reg};
        tmag        = tdiff[16] ? 16'(~tdiff + 17'd1) : tdiff[15:0];
        tneg1_next  = tdiff[16];
        tprod1_next = 26'(tmag) * 26'(TEMP_SCALE);
    end

    // ------------------------------------------------------------------
    // Stage 2: divide by 100 and by the temperature divisor
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [48:0] p;
        logic [52:0] tp;
        for (int i = 0; i < 3; i++)
        begin
            p = 49'(prod1_reg[i]) * 49'(RECIP_100);
            quot2_next[i] = p[RECIP_100_SHR +: 18];
        end
        tp          = 53'(tprod1_reg) * 53'(RECIP_TEMP);
        tquot2_next = tp[RECIP_TEMP_SHR +: 18];
    end

    // ------------------------------------------------------------------
    // Stage 3: sensitivity, resolution shift folded with the first /8 of
    // the /1000, and the temperature offset
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [29:0] m;
        logic [32:0] sh;
        logic [11:0] sens;
        logic [TEMP_W-1:0] tq;
        for (int i = 0; i < 3; i++)
        begin
            sens = (i == 2) ? z_sensitivity_reg : xy_sensitivity_reg;
            m    = 30'(quot2_reg[i]) * 30'(sens);
            sh   = 33'(m) << resolution_select_reg;
            scaled3_next[i] = sh[32:3];
        end
        tq = {1'b0, tquot2_reg};
        temp3_next = {{(TEMP_W-16){temp_offset_reg[15]}}, temp_offset_reg}
                   + (tneg2_reg ? (~tq + 19'd1) : tq);
    end

    // ------------------------------------------------------------------
    // Stage 4: the remaining divide by 125, sign and error masking
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [60:0] p;
        logic [FIELD_W-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            p = 61'(scaled3_reg[i]) * 61'(RECIP_125);
            q = {1'b0, p[RECIP_125_SHR +: 23]};
            if (err3_reg)
                field4_next[i] = '0;
            else
                field4_next[i] = neg3_reg[i] ? (~q + 24'd1) : q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        err1_reg   <= status_byte[STATUS_ERR_POS];
        err2_reg   <= err1_reg;
        err3_reg   <= err2_reg;
        tneg1_reg  <= tneg1_next;
        tprod1_reg <= tprod1_next;
        tneg2_reg  <= tneg1_reg;
        tquot2_reg <= tquot2_next;
        temp3_reg  <= temp3_next;
        for (int i = 0; i < 3; i++)
        begin
            neg1_reg[i]    <= neg1_next[i];
            prod1_reg[i]   <= prod1_next[i];
            neg2_reg[i]    <= neg1_reg[i];
            quot2_reg[i]   <= quot2_next[i];
            neg3_reg[i]    <= neg2_reg[i];
            scaled3_reg[i] <= scaled3_next[i];
        end
        temp_value_reg <= err3_reg ? '0 : temp3_reg;
        field_x_reg    <= field4_next[0];
        field_y_reg    <= field4_next[1];
        field_z_reg    <= field4_next[2];
        read_error_reg <= err3_reg;
    end

    assign done       = v4_reg;
    assign temp_value = temp_value_reg;
    assign field_x    = field_x_reg;
    assign field_y    = field_y_reg;
    assign field_z    = field_z_reg;
    assign read_error = read_error_reg;

endmodule

// ===== design/magfc_checker.sv =====
// ----------------------------------------------------------------------------
// magfc_checker: port-level checks for the frame converter
// Watches requests and results on the top-level ports.
// ----------------------------------------------------------------------------
module magfc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [7:0]  status_byte,
    input logic        done,
    input logic [18:0] temp_value,
    input logic [23:0] field_x,
    input logic [23:0] field_y,
    input logic [23:0] field_z,
    input logic        read_error
);

    // Every accepted request is followed by a result.
    a_request_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("request did not produce a result after four cycles");

    // No result appears without a matching earlier request.
    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without a matching request");

    // The error flag follows the status byte of the same request.
    a_error_follows_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (read_error == $past(status_byte[4], 4)))
        else $error("read_error does not match the request status byte");

    // A flagged frame carries all-zero values.
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_error) |->
            (temp_value == 19'd0 && field_x == 24'd0 &&
             field_y == 24'd0 && field_z == 24'd0))
        else $error("flagged frame has nonzero values");

endmodule

bind magnetometer_frame_converter_core magfc_checker u_magfc_checker (.*);
